// ===== src/aesr_pkg.sv =====
// Shared types, S-box table and GF(2^8) helper for the AES round pipeline.
package aesr_pkg;

    // Sixteen state bytes, byte 0 in the top bits (FIPS-197 column-major order).
    typedef logic [0:15][7:0] aesr_block_t;

    // One state column, row 0 first.
    typedef logic [0:3][7:0] aesr_column_t;

    localparam logic [7:0] GF_REDUCE = 8'h1b;

    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] v;
        begin
            v = {a[6:0], 1'b0};
            if (a[7])
            begin
                v = v ^ GF_REDUCE;
            end
            return v;
        end
    endfunction

endpackage

// ===== src/aesr_sub_bytes.sv =====
// SubBytes: sixteen parallel S-box lookups.
module aesr_sub_bytes (
    input  aesr_pkg::aesr_block_t din,
    output aesr_pkg::aesr_block_t dout
);
    import aesr_pkg::*;

    genvar i;
    generate
        for (i = 0; i < 16; i++)
        begin : g_byte
            assign dout[i] = SBOX_TABLE[din[i]];
        end
    endgenerate

endmodule

// ===== src/aesr_mix_column.sv =====
// MixColumns for one state column.
module aesr_mix_column (
    input  aesr_pkg::aesr_column_t col_in,
    output aesr_pkg::aesr_column_t col_out
);
    import aesr_pkg::*;

    logic [7:0] all_xor;

    assign all_xor = col_in[0] ^ col_in[1] ^ col_in[2] ^ col_in[3];

    genvar r;
    generate
        for (r = 0; r < 4; r++)
        begin : g_row
            assign col_out[r] = gf_xtime(col_in[r] ^ col_in[(r + 1) % 4])
                                ^ col_in[r] ^ all_xor;
        end
    endgenerate

endmodule

// ===== src/aes_encrypt_round.sv =====
// Top level: three-stage pipelined AES encryption middle round.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid, in_stall   | state_hi, state_lo, key_hi, key_lo
//  out     | out_valid, out_stall | result_hi, result_lo
//
// An accepted item moves through the stage 1, 2 and 3 registers; out_valid rises once it
// reaches stage 3. One item enters per cycle while the output side keeps taking results.
// Stage 1 registers the S-box outputs, stage 2 applies ShiftRows and
// MixColumns, stage 3 adds the round key and drives the result ports.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall holds the last stage; earlier stages keep advancing into empty
// slots, so bubbles collapse and nothing is dropped or repeated.
module aes_encrypt_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] state_hi,
    input  logic [63:0] state_lo,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);
    import aesr_pkg::*;

    // Stage valid bits and payload.
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    aesr_block_t sub_reg;
    aesr_block_t key1_reg;
    aesr_block_t mix_reg;
    aesr_block_t key2_reg;
    aesr_block_t res_reg;

    // Combinational results feeding each stage.
    aesr_block_t in_block;
    aesr_block_t sub_next;
    aesr_block_t shift_block;
    aesr_block_t mix_next;
    aesr_block_t res_next;

    // Per-stage advance: a stage loads when it is empty or its content moves on.
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // Stage 1: SubBytes straight from the input ports.
    assign in_block = {state_hi, state_lo};

    aesr_sub_bytes u_sub_bytes (
        .din  (in_block),
        .dout (sub_next)
    );

    // Stage 2: ShiftRows rotates row r left by r columns, then MixColumns.
    genvar c;
    genvar r;
    generate
        for (c = 0; c < 4; c++)
        begin : g_col
            for (r = 0; r < 4; r++)
            begin : g_row
                assign shift_block[4 * c + r] = sub_reg[4 * ((c + r) % 4) + r];
            end

            aesr_mix_column u_mix_column (
                .col_in  (shift_block[4 * c : 4 * c + 3]),
                .col_out (mix_next[4 * c : 4 * c + 3])
            );
        end
    endgenerate

    // Stage 3: AddRoundKey.
    assign res_next = mix_reg ^ key2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            sub_reg  <= sub_next;
            key1_reg <= {key_hi, key_lo};
        end
        if (s2_ready && s1_valid_reg)
        begin
            mix_reg  <= mix_next;
            key2_reg <= key1_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign result_hi = res_reg[0:7];
    assign result_lo = res_reg[8:15];

    // An accepted item always lands in stage 1.
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted item missing from stage 1");

    // An empty first stage never pushes back on the input.
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty stage 1");

    // A blocked middle stage holds its item.
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(mix_reg)
                                      && $stable(key2_reg))
        else $error("stage 2 item lost under stall");

    // A stage-1 item that can advance reaches stage 2.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> s2_valid_reg)
        else $error("stage 1 item dropped");

endmodule
